### rtl/dsdt_pkg.sv
package dsdt_pkg;

    // Table layout
    localparam int unsigned HEADER_BYTES = 36;
    localparam logic [31:0] SIG_RESET    = 32'h5444_5344;  // "DSDT", byte 0 in bits 7..0
    localparam logic [31:0] INDEX_MAX    = 32'hFFFF_FFFF;

    // AML opcodes and name bytes
    localparam logic [7:0] AML_NAME_OP  = 8'h08;
    localparam logic [7:0] AML_ROOT     = 8'h5C;
    localparam logic [7:0] AML_PKG_OP   = 8'h12;
    localparam logic [7:0] AML_BYTE_PFX = 8'h0A;
    localparam logic [7:0] AML_LEN_MASK = 8'hC0;
    localparam logic [7:0] CHR_UNDER    = 8'h5F;
    localparam logic [7:0] CHR_S        = 8'h53;
    localparam logic [7:0] CHR_5        = 8'h35;

    // Sleep value position in the PM1 control word
    localparam int unsigned SLP_SHIFT = 10;

    // Widths of the packed output item
    localparam int unsigned OUT_BITS = 35;
    localparam int unsigned OUT_PAD  = 40;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_SIG   = 3'd1,
        ST_BAD_SUM   = 3'd2,
        ST_NO_S5     = 3'd3,
        ST_PARSE_ERR = 3'd4,
        ST_TRUNC     = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        PH_SEARCH   = 4'd0,
        PH_PKGOP    = 4'd1,
        PH_PKGLEN   = 4'd2,
        PH_SKIP     = 4'd3,
        PH_A_PREFIX = 4'd4,
        PH_A_VALUE  = 4'd5,
        PH_B_PREFIX = 4'd6,
        PH_B_VALUE  = 4'd7,
        PH_DONE     = 4'd8,
        PH_FAIL     = 4'd9
    } phase_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] word_a;
        logic [15:0] word_b;
    } result_t;

    function automatic logic [15:0] slp_word(input logic [7:0] b);
        logic [15:0] w;
        w = {b[5:0], 10'd0};
        return w;
    endfunction

endpackage

### rtl/dsdt_scan.sv
module dsdt_scan (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [31:0]            cfg_wr_data,
    input  logic                   step_en,
    input  logic [7:0]             step_byte,
    input  logic                   step_last,
    output dsdt_pkg::result_t      result
);
    import dsdt_pkg::*;

    logic [31:0] sig_reg;
    logic [31:0] index_reg, index_next;
    logic [31:0] len_reg, len_next;
    logic [7:0]  sum_reg, sum_next;
    logic        sig_ok_reg, sig_ok_next;
    logic [7:0]  recent_reg [6];
    logic [7:0]  recent_next [6];
    phase_t      phase_reg, phase_next;
    logic [2:0]  skip_reg, skip_next;
    logic [15:0] val_a_reg, val_a_next;
    logic [15:0] val_b_reg, val_b_next;

    logic [31:0] pos;
    logic [32:0] count;
    logic        in_table;
    logic        s5_hit;
    logic        named;
    logic [7:0]  sig_byte;

    assign pos   = index_reg;
    assign count = {1'b0, index_reg} + 33'd1;

    // Per-byte state update
    always_comb
    begin
        index_next  = (index_reg != INDEX_MAX) ? index_reg + 32'd1 : index_reg;
        len_next    = len_reg;
        sum_next    = sum_reg;
        sig_ok_next = sig_ok_reg;
        phase_next  = phase_reg;
        skip_next   = skip_reg;
        val_a_next  = val_a_reg;
        val_b_next  = val_b_reg;
        for (int k = 0; k < 5; k++)
        begin
            recent_next[k] = recent_reg[k + 1];
        end
        recent_next[5] = step_byte;

        // Signature bytes and length field
        sig_byte = sig_reg[pos[1:0]*8 +: 8];
        if (pos < 32'd4)
        begin
            if (step_byte != sig_byte)
                sig_ok_next = 1'b0;
        end
        else if (pos < 32'd8)
        begin
            len_next[pos[1:0]*8 +: 8] = step_byte;
        end

        // _S5_ name with NameOp (or NameOp plus root prefix) in front
        s5_hit = (pos >= 32'(HEADER_BYTES + 3)) &&
                 recent_next[2] == CHR_UNDER && recent_next[3] == CHR_S &&
                 recent_next[4] == CHR_5 && recent_next[5] == CHR_UNDER;
        named  = recent_next[1] == AML_NAME_OP ||
                 (recent_next[0] == AML_NAME_OP && recent_next[1] == AML_ROOT);

        // Checksum and parse over the table body only
        in_table = (pos < 32'd8) || (pos < len_reg);
        if (in_table)
        begin
            sum_next = sum_reg + step_byte;
            if (pos >= 32'd8)
            begin
                unique case (phase_reg)
                    PH_SEARCH:
                        if (s5_hit)
                            phase_next = named ? PH_PKGOP : PH_FAIL;
                    PH_PKGOP:
                        phase_next = (step_byte == AML_PKG_OP) ? PH_PKGLEN : PH_FAIL;
                    PH_PKGLEN:
                    begin
                        skip_next  = {1'b0, step_byte[7:6]} + 3'd1;
                        phase_next = PH_SKIP;
                    end
                    PH_SKIP:
                    begin
                        skip_next = skip_reg - 3'd1;
                        if (skip_reg == 3'd1)
                            phase_next = PH_A_PREFIX;
                    end
                    PH_A_PREFIX:
                        if (step_byte == AML_BYTE_PFX)
                            phase_next = PH_A_VALUE;
                        else
                        begin
                            val_a_next = slp_word(step_byte);
                            phase_next = PH_B_PREFIX;
                        end
                    PH_A_VALUE:
                    begin
                        val_a_next = slp_word(step_byte);
                        phase_next = PH_B_PREFIX;
                    end
                    PH_B_PREFIX:
                        if (step_byte == AML_BYTE_PFX)
                            phase_next = PH_B_VALUE;
                        else
                        begin
                            val_b_next = slp_word(step_byte);
                            phase_next = PH_DONE;
                        end
                    PH_B_VALUE:
                    begin
                        val_b_next = slp_word(step_byte);
                        phase_next = PH_DONE;
                    end
                    default:
                        phase_next = phase_reg;
                endcase
            end
        end
    end

    // Final status, by priority
    always_comb
    begin
        if (pos < 32'd3)
            result.status = ST_TRUNC;
        else if (!sig_ok_next)
            result.status = ST_BAD_SIG;
        else if (pos < 32'd7 || count < {1'b0, len_next})
            result.status = ST_TRUNC;
        else if (len_next < 32'd8 || sum_next != 8'd0)
            result.status = ST_BAD_SUM;
        else if (phase_next == PH_SEARCH)
            result.status = ST_NO_S5;
        else if (phase_next != PH_DONE)
            result.status = ST_PARSE_ERR;
        else
            result.status = ST_OK;
        result.word_a = (result.status == ST_OK) ? val_a_next : 16'd0;
        result.word_b = (result.status == ST_OK) ? val_b_next : 16'd0;
    end

    // Signature register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sig_reg <= SIG_RESET;
        else if (cfg_wr_en)
            sig_reg <= cfg_wr_data;
    end

    // Stream state; cleared after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg  <= '0;
            len_reg    <= '0;
            sum_reg    <= '0;
            sig_ok_reg <= 1'b1;
            phase_reg  <= PH_SEARCH;
            skip_reg   <= '0;
            val_a_reg  <= '0;
            val_b_reg  <= '0;
            for (int k = 0; k < 6; k++)
            begin
                recent_reg[k] <= '0;
            end
        end
        else if (step_en)
        begin
            if (step_last)
            begin
                index_reg  <= '0;
                len_reg    <= '0;
                sum_reg    <= '0;
                sig_ok_reg <= 1'b1;
                phase_reg  <= PH_SEARCH;
                skip_reg   <= '0;
                val_a_reg  <= '0;
                val_b_reg  <= '0;
                for (int k = 0; k < 6; k++)
                begin
                    recent_reg[k] <= '0;
                end
            end
            else
            begin
                index_reg  <= index_next;
                len_reg    <= len_next;
                sum_reg    <= sum_next;
                sig_ok_reg <= sig_ok_next;
                phase_reg  <= phase_next;
                skip_reg   <= skip_next;
                val_a_reg  <= val_a_next;
                val_b_reg  <= val_b_next;
                for (int k = 0; k < 6; k++)
                begin
                    recent_reg[k] <= recent_next[k];
                end
            end
        end
    end

    // Skip counter is live whenever the skip phase is
    a_skip_live: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SKIP |-> skip_reg != 3'd0)
        else $error("skip phase with empty skip count");

    // A finished table leaves the stream state cleared
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && step_last |=> index_reg == 32'd0 && phase_reg == PH_SEARCH)
        else $error("stream state not cleared after last byte");

    // The parser never leaves the search before the header is past
    a_search_header: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_SEARCH |-> index_reg > 32'(HEADER_BYTES + 3))
        else $error("parse phase advanced inside the header");

endmodule

### rtl/dsdt_sleep_type_extract.sv
// Channel     Dir  tdata (low bit up)                         tuser  tlast
// s_axis      in   table_byte[7:0]                            -      last_byte
// m_axis      out  status[2:0] word_a[18:3] word_b[34:19]     -      -
// cfg_wr_*    in   expected_signature[31:0], no read-back     -      -
//
// One byte per cycle sustained unless a stalled result holds a last byte back; an
// item passes an input register, then the stream state update and result register.
// Only the last byte of a table makes a result.
// rst_n clears the stream state and sets the signature to "DSDT".
// A stalled result holds only last bytes back; other bytes keep flowing.
module dsdt_sleep_type_extract (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // table_byte[7:0]
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // status[2:0], sleep_word_a[18:3], sleep_word_b[34:19]
);
    import dsdt_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       advance;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;
    result_t    step_result;

    // Input stage moves on unless a result has nowhere to go
    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    dsdt_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step_en     (advance),
        .step_byte   (in_byte_reg),
        .step_last   (in_last_reg),
        .result      (step_result)
    );

    // Result register
    always_comb
    begin
        if (advance && in_last_reg)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
            out_reg <= step_result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_PAD - OUT_BITS)'(0), out_reg.word_b, out_reg.word_a,
                            out_reg.status};

    // A result is only written into a free or draining result register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |-> !out_valid_reg || m_axis_tready)
        else $error("result register overwritten");

    // A held input item is not dropped
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input item lost while stalled");

    // Sleep words are zero unless the table parsed cleanly
    a_words_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status != ST_OK |->
            out_reg.word_a == 16'd0 && out_reg.word_b == 16'd0)
        else $error("sleep words set on a failed table");

endmodule

### verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dsdt_pkg::*;

    localparam int GAP_MAX      = 8;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_LIMIT   = 400;
    localparam int SIG_BYTES    = 4;
    localparam int LEN_END      = 8;
    localparam int SUM_POS      = 9;
    localparam int RANDOM_BYTES = 300;

    typedef enum int {FORM_ABSENT, FORM_NAME, FORM_ROOT, FORM_BADPFX} s5_form_t;
    typedef enum int {MUT_NONE, MUT_SIG, MUT_SUM, MUT_TRUNC, MUT_TAIL, MUT_CUT} damage_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [31:0] cfg_wr_data   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // table_byte[7:0]
    logic        s_axis_tlast  = 1'b0; // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // status[2:0], sleep_word_a[18:3], sleep_word_b[34:19]

    dsdt_sleep_type_extract dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the parser state
    logic [31:0] sig_reg;
    logic [31:0] seen_count;
    logic [31:0] tbl_len;
    logic [7:0]  byte_sum;
    logic        sig_match;
    logic [7:0]  window [6];
    phase_t      phase;
    logic [2:0]  skip_cnt;
    logic [15:0] word_a;
    logic [15:0] word_b;

    result_t     expected_reports [$];
    logic [7:0]  tbl [$];
    int          s5_end;
    int          fail_count    = 0;
    int          bytes_sent    = 0;
    bit          tx_steady     = 1'b0;
    bit          rx_steady     = 1'b0;
    int          idle_cycles   = 0;

    function automatic logic [15:0] sleep_field(input logic [7:0] b);
        logic [15:0] w;
        w = 16'(b) << SLP_SHIFT;
        return w;
    endfunction

    function automatic void clear_tracking();
        seen_count = '0;
        tbl_len    = '0;
        byte_sum   = '0;
        sig_match  = 1'b1;
        foreach (window[k])
            window[k] = '0;
        phase    = PH_SEARCH;
        skip_cnt = '0;
        word_a   = '0;
        word_b   = '0;
    endfunction

    // AML walk for one in-table byte past the signature and length fields
    function automatic void step_parse(input logic [31:0] pos, input logic [7:0] b);
        logic       named;
        logic [7:0] lead;
        case (phase)
            PH_SEARCH:
                if (pos >= HEADER_BYTES + 3 && window[2] == CHR_UNDER && window[3] == CHR_S &&
                    window[4] == CHR_5 && window[5] == CHR_UNDER)
                begin
                    named = (window[1] == AML_NAME_OP) ||
                            (window[0] == AML_NAME_OP && window[1] == AML_ROOT);
                    phase = named ? PH_PKGOP : PH_FAIL;
                end
            PH_PKGOP:
                phase = (b == AML_PKG_OP) ? PH_PKGLEN : PH_FAIL;
            PH_PKGLEN:
            begin
                lead     = b & AML_LEN_MASK;
                skip_cnt = {1'b0, lead[7:6]} + 3'd1;
                phase    = PH_SKIP;
            end
            PH_SKIP:
            begin
                skip_cnt = skip_cnt - 3'd1;
                if (skip_cnt == 3'd0)
                    phase = PH_A_PREFIX;
            end
            PH_A_PREFIX:
                if (b == AML_BYTE_PFX)
                    phase = PH_A_VALUE;
                else
                begin
                    word_a = sleep_field(b);
                    phase  = PH_B_PREFIX;
                end
            PH_A_VALUE:
            begin
                word_a = sleep_field(b);
                phase  = PH_B_PREFIX;
            end
            PH_B_PREFIX:
                if (b == AML_BYTE_PFX)
                    phase = PH_B_VALUE;
                else
                begin
                    word_b = sleep_field(b);
                    phase  = PH_DONE;
                end
            PH_B_VALUE:
            begin
                word_b = sleep_field(b);
                phase  = PH_DONE;
            end
            default: ;
        endcase
    endfunction

    // Track one accepted byte; at the last byte queue the expected report
    function automatic void absorb_byte(input logic [7:0] b, input logic last);
        logic [31:0] pos;
        logic [32:0] count;
        status_t     st;
        result_t     r;
        pos   = seen_count;
        count = {1'b0, pos} + 33'd1;
        for (int k = 0; k < 5; k++)
            window[k] = window[k + 1];
        window[5] = b;

        if (pos < SIG_BYTES)
        begin
            if (b != sig_reg[8 * pos[1:0] +: 8])
                sig_match = 1'b0;
        end
        else if (pos < LEN_END)
            tbl_len = tbl_len | (32'(b) << (8 * pos[1:0]));

        if (pos < LEN_END || pos < tbl_len)
        begin
            byte_sum = byte_sum + b;
            if (pos >= LEN_END)
                step_parse(pos, b);
        end

        if (seen_count != INDEX_MAX)
            seen_count = seen_count + 32'd1;

        if (last)
        begin
            if (count < SIG_BYTES)
                st = ST_TRUNC;
            else if (!sig_match)
                st = ST_BAD_SIG;
            else if (count < LEN_END || count < {1'b0, tbl_len})
                st = ST_TRUNC;
            else if (tbl_len < LEN_END || byte_sum != 8'd0)
                st = ST_BAD_SUM;
            else if (phase == PH_SEARCH)
                st = ST_NO_S5;
            else if (phase != PH_DONE)
                st = ST_PARSE_ERR;
            else
                st = ST_OK;
            r.status = st;
            r.word_a = (st == ST_OK) ? word_a : 16'd0;
            r.word_b = (st == ST_OK) ? word_b : 16'd0;
            expected_reports.push_back(r);
            clear_tracking();
        end
    endfunction

    function automatic logic [7:0] rand_byte_except(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] v;
        do
            v = 8'($urandom);
        while (v == x || v == y);
        return v;
    endfunction

    function automatic void start_header(input logic [31:0] len);
        tbl.delete();
        for (int i = 0; i < SIG_BYTES; i++)
            tbl.push_back(sig_reg[8 * i +: 8]);
        for (int i = 0; i < 4; i++)
            tbl.push_back(len[8 * i +: 8]);
    endfunction

    // Length field plus a checksum byte that zeroes the sum over len bytes
    function automatic void set_length(input int len);
        logic [31:0] l;
        logic [7:0]  s;
        l = len;
        for (int i = 0; i < 4; i++)
            tbl[SIG_BYTES + i] = l[8 * i +: 8];
        tbl[SUM_POS] = 8'd0;
        s = 8'd0;
        for (int i = 0; i < len && i < tbl.size(); i++)
            s = s + tbl[i];
        tbl[SUM_POS] = 8'd0 - s;
    endfunction

    // Header, optional filler, a _S5_ package of the given shape (if any), then trailing filler
    function automatic void build_table(input int pre, input s5_form_t form, input bit pkg_ok,
                                        input int lead_n, input bit pfx_a, input bit pfx_b,
                                        input logic [7:0] va, input logic [7:0] vb,
                                        input int post);
        logic [7:0] lead;
        start_header(32'd0);
        for (int i = LEN_END; i < HEADER_BYTES; i++)
            tbl.push_back(8'($urandom));
        if (pre < 0)
            repeat (-pre) void'(tbl.pop_back());
        else
            repeat (pre) tbl.push_back(8'($urandom));
        s5_end = -1;
        case (form)
            FORM_NAME:   tbl.push_back(AML_NAME_OP);
            FORM_ROOT:
            begin
                tbl.push_back(AML_NAME_OP);
                tbl.push_back(AML_ROOT);
            end
            FORM_BADPFX: tbl.push_back(rand_byte_except(AML_NAME_OP, AML_ROOT));
            default: ;
        endcase
        if (form != FORM_ABSENT)
        begin
            tbl.push_back(CHR_UNDER);
            tbl.push_back(CHR_S);
            tbl.push_back(CHR_5);
            tbl.push_back(CHR_UNDER);
            s5_end = tbl.size() - 1;
            tbl.push_back(pkg_ok ? AML_PKG_OP : rand_byte_except(AML_PKG_OP, AML_PKG_OP));
            lead = {2'(lead_n), 6'($urandom)};
            tbl.push_back(lead);
            repeat (lead_n) tbl.push_back(8'($urandom));
            tbl.push_back(8'($urandom));   // element count
            if (pfx_a)
                tbl.push_back(AML_BYTE_PFX);
            tbl.push_back(va);
            if (pfx_b)
                tbl.push_back(AML_BYTE_PFX);
            tbl.push_back(vb);
        end
        repeat (post) tbl.push_back(8'($urandom));
        set_length(tbl.size());
    endfunction

    function automatic void damage(input damage_t m);
        int idx;
        case (m)
            MUT_SIG:
            begin
                idx = $urandom_range(0, SIG_BYTES - 1);
                tbl[idx] = tbl[idx] ^ 8'($urandom_range(1, 255));
            end
            MUT_SUM:
            begin
                idx = $urandom_range(SUM_POS + 1, tbl.size() - 1);
                tbl[idx] = tbl[idx] ^ 8'($urandom_range(1, 255));
            end
            MUT_TRUNC:
                repeat ($urandom_range(1, tbl.size() - 1)) void'(tbl.pop_back());
            MUT_TAIL:
                repeat ($urandom_range(1, 8)) tbl.push_back(8'($urandom));
            MUT_CUT:
                set_length($urandom_range(HEADER_BYTES, tbl.size() - 1));
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // One item on the input side, with a random hold-off before it unless tx_steady is set
    task automatic send_item(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        absorb_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_table();
        for (int i = 0; i < tbl.size(); i++)
            send_item(tbl[i], i == tbl.size() - 1);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_signature(input logic [31:0] v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sig_reg = v;
    endtask

    // Streams shorter than a header: partial and complete signature and length fields
    task automatic test_short_streams();
        start_header(32'd0);
        repeat (7) void'(tbl.pop_back());
        send_table();
        start_header(32'd0);
        repeat (5) void'(tbl.pop_back());
        send_table();
        start_header(32'd0);
        tbl[2] = tbl[2] ^ 8'h01;
        repeat (4) void'(tbl.pop_back());
        send_table();
        start_header(32'd0);
        repeat (4) void'(tbl.pop_back());
        send_table();
        start_header(32'd0);
        send_table();
        start_header(32'hFFFF_FFFF);
        send_table();
        wait_idle();
    endtask

    // Each package shape and each way the table end can cut it
    task automatic test_s5_forms();
        build_table(0, FORM_NAME, 1, 0, 0, 0, 8'h00, 8'h00, 0);
        send_table();
        build_table(3, FORM_ROOT, 1, 3, 1, 1, 8'hFF, 8'hFF, 4);
        send_table();
        build_table(1, FORM_NAME, 1, 1, 1, 0, 8'h05, 8'h07, 2);
        send_table();
        build_table(2, FORM_ROOT, 1, 2, 0, 1, 8'h3F, 8'h40, 0);
        send_table();
        // name starting at the first body offset, and one byte too early
        build_table(-1, FORM_NAME, 1, 0, 0, 0, 8'h01, 8'h02, 1);
        send_table();
        build_table(-2, FORM_NAME, 1, 0, 0, 0, 8'h01, 8'h02, 1);
        send_table();
        build_table(0, FORM_BADPFX, 1, 0, 0, 0, 8'h05, 8'h05, 2);
        send_table();
        build_table(0, FORM_NAME, 0, 0, 0, 0, 8'h05, 8'h05, 2);
        send_table();
        build_table(5, FORM_ABSENT, 1, 0, 0, 0, 8'h00, 8'h00, 3);
        send_table();
        // match ending on the final table byte, then straddling the end
        build_table(0, FORM_NAME, 1, 1, 1, 1, 8'h07, 8'h07, 0);
        set_length(s5_end + 1);
        send_table();
        build_table(0, FORM_NAME, 1, 1, 1, 1, 8'h07, 8'h07, 0);
        set_length(s5_end);
        send_table();
        build_table(0, FORM_ROOT, 1, 0, 1, 1, 8'h07, 8'h07, 0);
        set_length(tbl.size() - 1);
        send_table();
        build_table(0, FORM_NAME, 1, 0, 0, 0, 8'h0B, 8'h0C, 0);
        damage(MUT_TAIL);
        send_table();
        build_table(0, FORM_NAME, 1, 0, 0, 0, 8'h0B, 8'h0C, 0);
        damage(MUT_TRUNC);
        send_table();
        wait_idle();
    endtask

    // Signature register at its extremes, a random value, and back to reset
    task automatic test_signatures();
        logic [31:0] sigs [4];
        sigs[0] = 32'h0000_0000;
        sigs[1] = 32'hFFFF_FFFF;
        sigs[2] = $urandom;
        sigs[3] = SIG_RESET;
        foreach (sigs[i])
        begin
            write_signature(sigs[i]);
            build_table(1, FORM_NAME, 1, 0, 1, 0, pick_value(), pick_value(), 1);
            send_table();
            build_table(1, FORM_ROOT, 1, 1, 0, 1, pick_value(), pick_value(), 1);
            damage(MUT_SIG);
            send_table();
            start_header(32'd0);
            repeat (4) void'(tbl.pop_back());
            send_table();
        end
        wait_idle();
    endtask

    // Random tables with random content, half of them damaged, and some noise
    task automatic test_random_tables();
        int       start_bytes;
        int       pre;
        int       sel;
        s5_form_t form;
        damage_t  dmg;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 9) == 0)
                tx_steady = !tx_steady;
            if ($urandom_range(0, 9) == 0)
                rx_steady = !rx_steady;
            if ($urandom_range(0, 19) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       write_signature(32'h0000_0000);
                    1:       write_signature(32'hFFFF_FFFF);
                    2:       write_signature($urandom);
                    default: write_signature(SIG_RESET);
                endcase
            end
            if ($urandom_range(0, 9) == 0)
            begin
                tbl.delete();
                repeat ($urandom_range(1, 10)) tbl.push_back(8'($urandom));
            end
            else
            begin
                pre = ($urandom_range(0, 15) == 0) ? -int'($urandom_range(1, 2))
                                                   : int'($urandom_range(0, 12));
                sel = $urandom_range(0, 9);
                if (sel < 5)
                    form = FORM_NAME;
                else if (sel < 8)
                    form = FORM_ROOT;
                else if (sel == 8)
                    form = FORM_BADPFX;
                else
                    form = FORM_ABSENT;
                build_table(pre, form, $urandom_range(0, 9) != 0, $urandom_range(0, 3),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            pick_value(), pick_value(), $urandom_range(0, 8));
                sel = $urandom_range(0, 11);
                case (sel)
                    6:       dmg = MUT_SIG;
                    7:       dmg = MUT_SUM;
                    8:       dmg = MUT_TRUNC;
                    9:       dmg = MUT_TAIL;
                    10, 11:  dmg = MUT_CUT;
                    default: dmg = MUT_NONE;
                endcase
                damage(dmg);
            end
            send_table();
        end
        wait_idle();
    endtask

    // Result side: random stall per item unless rx_steady, then compare with the oldest report
    initial
    begin : result_checker
        int         stall;
        result_t    want;
        logic [2:0] got_status;
        logic [15:0] got_a;
        logic [15:0] got_b;
        logic [4:0] got_pad;
        wait (rst_n);
        forever
        begin
            stall = rx_steady ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
            got_status = m_axis_tdata[2:0];
            got_a      = m_axis_tdata[18:3];
            got_b      = m_axis_tdata[34:19];
            got_pad    = m_axis_tdata[39:35];
            if (expected_reports.size() == 0)
            begin
                $display("%0t: unexpected report, expected none, actual status %0d",
                         $time, got_status);
                fail_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got_status != want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             got_status);
                    fail_count++;
                end
                if (got_a != want.word_a)
                begin
                    $display("%0t: sleep_word_a expected %h actual %h", $time, want.word_a,
                             got_a);
                    fail_count++;
                end
                if (got_b != want.word_b)
                begin
                    $display("%0t: sleep_word_b expected %h actual %h", $time, want.word_b,
                             got_b);
                    fail_count++;
                end
                if (got_pad != 5'd0)
                begin
                    $display("%0t: tdata pad expected %h actual %h", $time, 5'd0, got_pad);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        sig_reg = SIG_RESET;
        clear_tracking();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_short_streams();
        test_s5_forms();
        test_signatures();
        test_random_tables();
        wait_idle();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
